### rtl/core/sfir_pkg.sv
// ---------------------------------------------------------------------------
// sfir_pkg: shared types and constants
// Field widths, request codes and the sequencer state type.
// ---------------------------------------------------------------------------
package sfir_pkg;
	localparam int SW = 24;
	localparam int CW = 4;
	localparam int IDXW = 4;
	localparam int OCHW = 3;
	localparam int ACCW = 64;
	localparam int DIGW = 4;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAC,
		ST_ROUND,
		ST_OUT0,
		ST_OUT1,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic start;
	} mac_ctl_t;
endpackage

### rtl/core/sfir_mac.sv
// ---------------------------------------------------------------------------
// sfir_mac: digit-serial multiply-accumulate
// Multiplies a signed coefficient by a signed pair sum, four bits of the
// pair sum per cycle, and adds the product into a wide accumulator.
// ---------------------------------------------------------------------------
module sfir_mac (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clr,
	input  sfir_pkg::mac_ctl_t      ctl,
	input  logic signed [23:0]      coef,
	input  logic signed [24:0]      pair,
	output logic signed [63:0]      acc
);
	import sfir_pkg::*;

	// The 25-bit pair is sign-extended to 28 bits: seven digits.
	localparam int ND = 7;
	logic [27:0]        mult_q;
	logic signed [63:0] acc_q;
	logic [2:0]         dig_q;
	logic               busy_q;
	logic signed [23:0] coef_q;
	logic signed [28:0] pp;

	// Top digit carries negative weight.
	always_comb begin
		if (dig_q == 3'(ND - 1))
			pp = 29'(coef_q * $signed({1'b0, mult_q[3:0]}) -
				(coef_q * $signed(6'sd16) * $signed({1'b0, mult_q[3]})));
		else
			pp = 29'(coef_q * $signed({1'b0, mult_q[3:0]}));
	end

	// Each digit product goes straight into the accumulator; the unit idles
	// between pairs so nothing is added twice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			dig_q <= '0;
			busy_q <= 1'b0;
			mult_q <= '0;
			coef_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
			dig_q <= '0;
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			dig_q <= 3'd0;
			busy_q <= 1'b1;
			mult_q <= 28'(pair);
			coef_q <= coef;
		end else if (busy_q) begin
			acc_q <= acc_q + (64'(pp) <<< (DIGW * int'(dig_q)));
			mult_q <= mult_q >> DIGW;
			if (dig_q == 3'(ND - 1)) begin
				dig_q <= 3'd0;
				busy_q <= 1'b0;
			end else
				dig_q <= dig_q + 3'd1;
		end
	end

	assign acc = acc_q;
endmodule

### rtl/core/symmetric_fir_upsample_by_two.sv
// ---------------------------------------------------------------------------
// symmetric_fir_upsample_by_two: two-times interpolator, symmetric FIR
// One word in gives two words out: the filtered even phase, then the
// delayed center sample as the odd phase.
// ---------------------------------------------------------------------------
// Usage: s_axis carries input words. tuser is req_type; tdata holds
// sample_in, coef_index and coef_value. A coefficient load is absorbed
// and produces nothing. A sample word steps through a sequencer that
// reads its channel's delay line from a ring in memory, two taps per
// tap pair, and feeds each pair sum to a shared digit-serial multiplier.
// Each pair steps through a read cycle, a start cycle and seven digits.
// The even word is offered after the MAC pass and the rounding state;
// a new sample word is accepted only when the sequencer is idle again.
// m_axis gives the even word (tuser phase 0) then the odd word with tlast.
// A stall on m_axis holds the word in the output register and keeps
// s_axis_tready low until both words have left.
// After reset a clearing pass zeroes the delay memory, one entry a cycle,
// all MAX_CHANNELS*(2*HALF_TAPS-1) entries, while s_axis_tready stays low.
// cfg writes set channel_count; write it only while the block is idle.
// ---------------------------------------------------------------------------
module symmetric_fir_upsample_by_two #(
	parameter int HALF_TAPS = 16,
	parameter int MAX_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [23:0] sample_in, [27:24] coef_index, [51:28] coef_value, zero fill
	input  logic [55:0] s_axis_tdata,
	// [0] req_type
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] out_channel, [26:3] sample_out, zero fill
	output logic [31:0] m_axis_tdata,
	// [0] phase
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import sfir_pkg::*;

	localparam int LL = 2 * HALF_TAPS - 1;
	localparam int DEPTH = MAX_CHANNELS * LL;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TW = $clog2(HALF_TAPS);
	localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNTW = $clog2(MAX_CHANNELS + 1);
	localparam int HW = $clog2(LL);

	state_t state_q, state_d;
	logic [3:0]  cnt_q;
	logic [PW-1:0] pos_q, ch_q, ch_sel;
	logic [AW-1:0] clr_q;
	logic [TW:0] t_q;
	logic [3:0]  sub_q;
	logic signed [SW-1:0] sample_q, center_q, ra_q, rb_q, out_q;
	logic signed [SW-1:0] coef_mem [HALF_TAPS];
	logic signed [SW-1:0] line_mem [DEPTH];
	logic signed [SW-1:0] ca_q;
	logic [HW-1:0] head_q [MAX_CHANNELS];
	logic [HW-1:0] head;
	logic [CNTW-1:0] eff;
	logic [AW-1:0] base, addr_a, addr_b, addr_w;
	logic mac_clr;
	mac_ctl_t mac_ctl;
	logic signed [63:0] acc;
	logic signed [63:0] rnd;
	logic signed [SW-1:0] sat;
	logic signed [24:0] pair;
	logic [IDXW-1:0] cidx;
	logic accept, take_sample, take_coef;
	logic [TW:0] kk;

	assign kk = (TW+1)'(HALF_TAPS);
	assign cidx = s_axis_tdata[27:24];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign take_sample = accept && (s_axis_tuser == REQ_SAMPLE);
	assign take_coef = accept && (s_axis_tuser == REQ_COEF) && (32'(cidx) < HALF_TAPS);
	assign cfg_ready = 1'b1;

	always_comb begin
		if (cnt_q == 4'd0)
			eff = CNTW'(1);
		else if (32'(cnt_q) > MAX_CHANNELS)
			eff = CNTW'(MAX_CHANNELS);
		else
			eff = CNTW'(cnt_q);
	end
	assign ch_sel = (CNTW'(pos_q) >= eff) ? '0 : pos_q;
	assign base = AW'(32'(ch_q) * LL);
	assign head = head_q[ch_q];

	// Window entry i (i < LL) sits i slots after the head, which holds the
	// oldest sample; the new sample replaces the head in the rounding state.
	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] b,
		input logic [HW-1:0] h, input int i);
		int r;
		r = int'(h) + i;
		if (r >= LL) r = r - LL;
		return AW'(int'(b) + r);
	endfunction

	assign addr_a = ring_addr(base, head, int'(t_q));
	assign addr_b = ring_addr(base, head, (t_q == '0) ? HALF_TAPS : LL - int'(t_q));
	assign addr_w = ring_addr(base, head, 0);

	always_comb begin
		unique case (state_q)
			ST_CLEAR: state_d = (32'(clr_q) == DEPTH - 1) ? ST_IDLE : ST_CLEAR;
			ST_IDLE:  state_d = take_sample ? ST_LOAD : ST_IDLE;
			ST_LOAD:  state_d = ST_MAC;
			ST_MAC:   state_d = (t_q == kk && sub_q == 4'd8) ? ST_ROUND : ST_MAC;
			ST_ROUND: state_d = ST_OUT0;
			ST_OUT0:  state_d = m_axis_tready ? ST_OUT1 : ST_OUT0;
			ST_OUT1:  state_d = m_axis_tready ? ST_IDLE : ST_OUT1;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		m_axis_tvalid = (state_q == ST_OUT0) || (state_q == ST_OUT1);
		m_axis_tuser = (state_q == ST_OUT1);
		m_axis_tlast = (state_q == ST_OUT1);
		m_axis_tdata = {5'd0, (state_q == ST_OUT1) ? center_q : out_q,
			3'(ch_q)};
		mac_clr = (state_q == ST_LOAD);
		mac_ctl.start = (state_q == ST_MAC) && (sub_q == 4'd0) && (t_q != 0);
	end

	// MAC schedule: per pair, the step with sub_q at 8 issues reads, the step with sub_q at 0
	// starts the multiplier and its seven digits follow. The last pair's product is
	// in the accumulator by the final step with sub_q at 8.
	assign pair = 25'(ra_q) + 25'(rb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= 4'd1;
			pos_q <= '0;
			ch_q <= '0;
			clr_q <= '0;
			t_q <= '0;
			sub_q <= '0;
			for (int c = 0; c < MAX_CHANNELS; c++) head_q[c] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) cnt_q <= cfg_data;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == ST_LOAD) begin
				t_q <= '0;
				sub_q <= 4'd8;
			end
			if (state_q == ST_MAC) begin
				if (sub_q == 4'd8) begin
					sub_q <= 4'd0;
					if (t_q != kk) t_q <= t_q + (TW+1)'(1);
				end else
					sub_q <= sub_q + 4'd1;
			end
			if (take_sample) begin
				ch_q <= ch_sel;
				pos_q <= ((CNTW'(ch_sel) + CNTW'(1)) >= eff) ? '0 : ch_sel + PW'(1);
			end
			if (state_q == ST_ROUND)
				head_q[ch_q] <= (32'(head) == LL - 1) ? '0 : head + HW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HALF_TAPS; i++) coef_mem[i] <= '0;
		end else if (take_coef)
			coef_mem[TW'(cidx)] <= s_axis_tdata[51:28];
	end

	always_ff @(posedge clk) begin
		if (accept)
			sample_q <= s_axis_tdata[23:0];
		if (state_q == ST_CLEAR)
			line_mem[clr_q] <= '0;
		if (state_q == ST_MAC && sub_q == 4'd8 && t_q < kk) begin
			ra_q <= line_mem[addr_a];
			rb_q <= (t_q == '0) ? sample_q : line_mem[addr_b];
			ca_q <= coef_mem[TW'(t_q)];
			// The first pair needs only one line read; the second port
			// fetches the center sample then.
			if (t_q == '0)
				center_q <= line_mem[addr_b];
		end
		if (state_q == ST_ROUND) begin
			out_q <= sat;
			line_mem[addr_w] <= sample_q;
		end
	end

	sfir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mac_clr),
		.ctl    (mac_ctl),
		.coef   (ca_q),
		.pair   (pair),
		.acc    (acc)
	);

	always_comb begin
		rnd = (acc + 64'sd4194304) >>> 23;
		if (rnd > 64'sd8388607) sat = 24'sh7FFFFF;
		else if (rnd < -64'sd8388608) sat = 24'sh800000;
		else sat = rnd[23:0];
	end

`ifndef SYNTHESIS
	a_no_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("output while accepting");
	a_last_after_even: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser) else $error("bad last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("dropped");
	a_data_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("data changed while stalled");
`endif
endmodule
